@@ rtl/fspa_pkg.sv @@
// Shared types, codes and constants of the free sector pool allocator.
package fspa_pkg;

  // Default pool depth; the top level takes it as a parameter.
  localparam int unsigned PoolDepthDef = 256;

  localparam int unsigned SectorW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  // End-of-chain marker; freeing it is a no-op.
  localparam logic [SectorW-1:0] EndMark = 32'hFFFF_FFFF;

  // Opcodes.
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Status codes.
  localparam logic [StatusW-1:0] StOk   = 2'd0;
  localparam logic [StatusW-1:0] StFull = 2'd1;
  localparam logic [StatusW-1:0] StNone = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFirstFresh  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSectorLimit = 2'd1;

  // Register reset values.
  localparam logic [SectorW-1:0] FirstFreshRst  = 32'd1;
  localparam logic [SectorW-1:0] SectorLimitRst = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               opcode;
    logic [SectorW-1:0] sector;
  } cmd_t;

  typedef struct packed {
    logic [SectorW-1:0] granted_sector;
    logic               was_fresh;
    logic [StatusW-1:0] status;
  } result_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StIns  = 3'b010,
    StPop  = 3'b100
  } state_e;

endpackage

@@ rtl/free_sector_pool_allocator.sv @@
// Free sector pool allocator: sorted free list in RAM, shift-one-per-cycle sequencer.
//
//  channel   handshake                 beat
//  --------  ------------------------  ----------------------------------
//  command   start & !busy             cmd_i     (opcode, sector)
//  result    result_valid_o (1 cycle)  result_o  (granted_sector, was_fresh, status)
//  config    cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
//  Flow: fresh allocations, failures, end-marker frees, full-pool frees and a free
//  into an empty pool finish in the accepting cycle; the result is registered and appears in the next cycle.
//  After the accepting cycle, a free walks down from the top, shifting each
//  larger-or-equal entry up one slot and then storing the sector; a pool
//  allocation reads the head and then moves each remaining entry down one slot. The
//  single RAM port pair and the one compare per step force this entry-by-entry walk.
//  Reset: pool empty, high water = 1, sector limit = all ones; no clearing pass.
//  The result strobe cannot be stalled; busy is low again when it appears.
module free_sector_pool_allocator
  import fspa_pkg::*;
#(
  parameter int unsigned PoolDepth = PoolDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cmd_t                cmd_i,
  output logic                result_valid_o,
  output result_t             result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [SectorW-1:0]  cfg_data_i
);

  localparam int unsigned AddrW  = (PoolDepth > 1) ? $clog2(PoolDepth) : 1;
  localparam int unsigned CountW = $clog2(PoolDepth + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(PoolDepth);

  state_e              state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [AddrW-1:0]    ptr_q, ptr_d;
  logic [SectorW-1:0]  sector_q, sector_d;
  logic [SectorW-1:0]  high_water_q, high_water_d;
  logic [SectorW-1:0]  limit_q;
  result_t             result_q, result_d;
  logic                result_valid_q, result_valid_d;

  logic                accept;
  logic                cfg_write;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [SectorW-1:0]  wr_data;
  logic [AddrW-1:0]    rd_addr;
  logic [SectorW-1:0]  rd_data;
  logic                entry_ge;
  logic                more_pop;
  logic                fresh_ok;

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Compare unit: stored entry against the sector being inserted.
  assign entry_ge = (rd_data >= sector_q);
  assign more_pop = ((CountW'(ptr_q) + CountW'(1)) < count_q);
  assign fresh_ok = (high_water_q < limit_q) && (high_water_q != EndMark);

  fspa_ram #(
    .Depth (PoolDepth),
    .Width (SectorW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequence accepts, shifts and results.
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    ptr_d          = ptr_q;
    sector_d       = sector_q;
    high_water_d   = high_water_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = ptr_q;
    wr_data        = sector_q;
    rd_addr        = ptr_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          result_d.granted_sector = '0;
          result_d.was_fresh      = 1'b0;
          result_d.status         = StOk;
          if (cmd_i.opcode == OpFree) begin
            if (cmd_i.sector == EndMark) begin
              result_valid_d = 1'b1;
            end else if (count_q >= CountMax) begin
              result_d.status = StFull;
              result_valid_d  = 1'b1;
            end else if (count_q == '0) begin
              // Empty pool: store at the head directly.
              wr_en          = 1'b1;
              wr_addr        = '0;
              wr_data        = cmd_i.sector;
              count_d        = CountW'(1);
              result_valid_d = 1'b1;
            end else begin
              // Walk down from the top, reading the entry below the open slot.
              sector_d = cmd_i.sector;
              ptr_d    = count_q[AddrW-1:0];
              rd_addr  = AddrW'(count_q - CountW'(1));
              state_d  = StIns;
            end
          end else begin
            if (count_q != '0) begin
              ptr_d   = '0;
              rd_addr = '0;
              state_d = StPop;
            end else if (fresh_ok) begin
              result_d.granted_sector = high_water_q;
              result_d.was_fresh      = 1'b1;
              high_water_d            = high_water_q + SectorW'(1);
              result_valid_d          = 1'b1;
            end else begin
              result_d.status = StNone;
              result_valid_d  = 1'b1;
            end
          end
        end
      end

      StIns: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        if ((ptr_q != '0) && entry_ge) begin
          // Shift the larger-or-equal entry up one slot.
          wr_data = rd_data;
          ptr_d   = ptr_q - AddrW'(1);
          rd_addr = ptr_q - AddrW'(2);
        end else begin
          wr_data        = sector_q;
          count_d        = count_q + CountW'(1);
          result_valid_d = 1'b1;
          state_d        = StIdle;
        end
      end

      StPop: begin
        if (ptr_q == '0) begin
          sector_d = rd_data;
        end else begin
          // Move the entry down one slot.
          wr_en   = 1'b1;
          wr_addr = ptr_q - AddrW'(1);
          wr_data = rd_data;
        end
        if (more_pop) begin
          ptr_d   = ptr_q + AddrW'(1);
          rd_addr = ptr_q + AddrW'(1);
        end else begin
          result_d.granted_sector = (ptr_q == '0) ? rd_data : sector_q;
          count_d                 = count_q - CountW'(1);
          result_valid_d          = 1'b1;
          state_d                 = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Load the high-water mark along with the first fresh sector.
    if (cfg_write && (cfg_index_i == CfgFirstFresh)) begin
      high_water_d = cfg_data_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      count_q        <= '0;
      high_water_q   <= FirstFreshRst;
      limit_q        <= SectorLimitRst;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      high_water_q   <= high_water_d;
      result_valid_q <= result_valid_d;
      if (cfg_write && (cfg_index_i == CfgSectorLimit)) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    sector_q <= sector_d;
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

@@ rtl/fspa_ram.sv @@
// Single-write, single-read sorted-pool storage with registered read data.
module fspa_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read data.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the free sector pool allocator.
`timescale 1ns / 100ps

module testbench;
  import fspa_pkg::*;

  localparam int unsigned PoolDepth     = PoolDepthDef;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = PoolDepth + 16;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  cmd_t                cmd_drv;
  logic                result_valid_o;
  result_t             res_mon;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [SectorW-1:0]  cfg_data_i;

  // Commands waiting to be driven and results waiting to be seen
  cmd_t        pending_cmd_q[$];
  result_t     grant_expect_q[$];

  // Shadow of the allocator: sorted pool, fresh counter, registers
  logic [SectorW-1:0] pool_q[$];
  logic [SectorW-1:0] high_water;
  logic [SectorW-1:0] sector_limit;
  logic [SectorW-1:0] first_fresh;

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  bit          cmd_taken = 1'b0;
  bit          burst_mode = 1'b0;

  free_sector_pool_allocator #(
    .PoolDepth(PoolDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_drv),
    .result_valid_o(result_valid_o),
    .result_o      (res_mon),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Toggle the clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Compute the result of one command and advance the shadow state
  function automatic result_t predict_grant(input cmd_t c);
    result_t     r;
    int unsigned pos;
    r = '0;
    r.status = StOk;
    if (c.opcode == OpFree) begin
      if (c.sector != EndMark) begin
        if (pool_q.size() >= PoolDepth) begin
          r.status = StFull;
        end else begin
          pos = 0;
          while (pos < pool_q.size() && pool_q[pos] < c.sector) pos++;
          pool_q.insert(pos, c.sector);
        end
      end
    end else if (pool_q.size() != 0) begin
      r.granted_sector = pool_q.pop_front();
    end else if (high_water < sector_limit && high_water != EndMark) begin
      r.granted_sector = high_water;
      r.was_fresh = 1'b1;
      high_water = high_water + 1;
    end else begin
      r.status = StNone;
    end
    return r;
  endfunction

  // Mirror a register write into the shadow state
  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [SectorW-1:0] val);
    case (idx)
      CfgFirstFresh: begin
        first_fresh = val;
        high_water = val;
      end
      CfgSectorLimit: begin
        sector_limit = val;
      end
      default: begin
      end
    endcase
  endfunction

  // Pick an idle gap: mostly none, some short, a few long
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick a sector: end marker, small values for duplicates, top values, or anything
  function automatic logic [SectorW-1:0] pick_sector();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return EndMark;
    if (r < 33) return SectorW'($urandom_range(0, 15));
    if (r < 43) return 32'hFFFF_FFF0 + SectorW'($urandom_range(0, 14));
    return SectorW'($urandom);
  endfunction

  // Queue one command
  task automatic push_cmd(input logic op, input logic [SectorW-1:0] s);
    cmd_t c;
    c.opcode = op;
    c.sector = s;
    pending_cmd_q.insert(pending_cmd_q.size(), c);
  endtask

  // Queue a run of random commands with the given share of frees
  task automatic queue_ops(input int unsigned count, input int unsigned free_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < free_pct) push_cmd(OpFree, pick_sector());
      else push_cmd(OpAlloc, SectorW'($urandom));
    end
  endtask

  // Wait until every command is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmd_q.size() != 0 || start || grant_expect_q.size() != 0 || busy);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register through the config channel
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SectorW-1:0] val);
    repeat ($urandom_range(1, 4)) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drive commands: hold a beat until taken, then idle or advance
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || cmd_taken) begin
        cmd_taken = 1'b0;
        if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending_cmd_q.size() != 0) begin
          cmd_drv <= pending_cmd_q.pop_front();
          start <= 1'b1;
          gap_left = next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check result beats, predict accepted commands, mirror register writes
  always @(posedge clk_i) begin : monitor
    result_t want;
    bit      progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (result_valid_o) begin
        progress = 1'b1;
        if (grant_expect_q.size() == 0) begin
          $error("result beat with nothing expected: %p", res_mon);
          fail_count++;
        end else begin
          want = grant_expect_q.pop_front();
          if (res_mon.granted_sector !== want.granted_sector) begin
            $error("granted_sector: expected %0h, got %0h",
                   want.granted_sector, res_mon.granted_sector);
            fail_count++;
          end
          if (res_mon.was_fresh !== want.was_fresh) begin
            $error("was_fresh: expected %0b, got %0b", want.was_fresh, res_mon.was_fresh);
            fail_count++;
          end
          if (res_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_mon.status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        grant_expect_q.insert(grant_expect_q.size(), predict_grant(cmd_drv));
        cmd_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        progress = 1'b1;
        apply_reg(cfg_index_i, cfg_data_i);
      end
      // Stop a hung run
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Reset, then run the directed part and the random phases
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_drv      = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    first_fresh  = FirstFreshRst;
    sector_limit = SectorLimitRst;
    high_water   = FirstFreshRst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fresh grants, end-marker free, extremes and duplicates in sorted order
    push_cmd(OpAlloc, 32'h0);
    push_cmd(OpFree, EndMark);
    push_cmd(OpAlloc, 32'hFFFF_FFFF);
    push_cmd(OpFree, 32'hFFFF_FFFE);
    push_cmd(OpFree, 32'h0);
    push_cmd(OpFree, 32'd5);
    push_cmd(OpFree, 32'd5);
    push_cmd(OpFree, 32'h0);
    repeat (5) push_cmd(OpAlloc, SectorW'($urandom));
    push_cmd(OpAlloc, 32'h5555_AAAA);
    wait_drained();

    // Exhaust fresh sectors against a low limit; pool still serves
    write_reg(CfgSectorLimit, 32'd4);
    push_cmd(OpAlloc, 32'hAAAA_5555);
    push_cmd(OpFree, 32'd7);
    push_cmd(OpAlloc, 32'h0);
    push_cmd(OpAlloc, 32'h0);
    wait_drained();

    // Fresh counter runs into the end marker
    write_reg(CfgFirstFresh, 32'hFFFF_FFFE);
    write_reg(CfgSectorLimit, 32'hFFFF_FFFF);
    push_cmd(OpAlloc, 32'h0);
    push_cmd(OpAlloc, 32'h0);
    push_cmd(OpFree, EndMark);
    push_cmd(OpAlloc, 32'h0);
    wait_drained();

    // Churn around a small pool with default-like settings
    write_reg(CfgFirstFresh, 32'd1);
    queue_ops(300, 50);
    wait_drained();

    // Tight fresh window; also poke an unused register index
    write_reg(CfgFirstFresh, SectorW'($urandom));
    write_reg(CfgSectorLimit, first_fresh + 32'd5);
    write_reg(2'd3, SectorW'($urandom));
    queue_ops(200, 40);
    wait_drained();

    // Fill the pool to overflow
    write_reg(CfgFirstFresh, 32'h0);
    write_reg(CfgSectorLimit, 32'hFFFF_FFFF);
    queue_ops(320, 98);
    wait_drained();

    // Drain the pool in order, then fall back to fresh sectors
    write_reg(CfgSectorLimit, SectorW'($urandom_range(20, 60)));
    queue_ops(300, 3);
    wait_drained();

    // Limit of 1, below the fresh counter: fresh allocation never allowed
    write_reg(CfgFirstFresh, 32'hFFFF_FFFE);
    write_reg(CfgSectorLimit, 32'd1);
    write_reg(2'd2, SectorW'($urandom));
    queue_ops(160, 45);
    wait_drained();

    // Fresh counter near the top, allocation heavy
    write_reg(CfgFirstFresh, 32'hFFFF_FFF0);
    write_reg(CfgSectorLimit, 32'hFFFF_FFFF);
    queue_ops(170, 25);
    wait_drained();

    repeat (TailCycles) @(negedge clk_i);
    if (grant_expect_q.size() != 0) begin
      $error("%0d results never arrived", grant_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fspa_pkg.sv
rtl/fspa_ram.sv
rtl/free_sector_pool_allocator.sv
sim/testbench.sv
